@@ design/groupcast_retry_policy_manager_unit_defines.svh @@
// Assertion macros included by the top-level unit.
`ifndef GROUPCAST_RETRY_POLICY_MANAGER_UNIT_DEFINES_SVH
`define GROUPCAST_RETRY_POLICY_MANAGER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked outside reset.
`define GRPM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define GRPM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GRPM_ASSERT(label, clk, rst, prop, msg)
`define GRPM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ design/grpm_pkg.sv @@
package grpm_pkg;

   localparam int MAX_STATIONS = 32;
   localparam int IDX_W = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
   localparam int CNT_RAW_W = $clog2(MAX_STATIONS + 1);
   localparam int CNT_W = (CNT_RAW_W > 6) ? CNT_RAW_W : 6;
   localparam int ADDR_W = 48;

   localparam logic [7:0] RESET_RETRY_LIMIT = 8'd7;

   // command codes
   localparam logic [1:0] CMD_ASSOC    = 2'd0;
   localparam logic [1:0] CMD_DEASSOC  = 2'd1;
   localparam logic [1:0] CMD_CLASSIFY = 2'd2;
   localparam logic [1:0] CMD_KEEP     = 2'd3;

   // policy codes
   localparam logic [1:0] POL_NONE  = 2'd0;
   localparam logic [1:0] POL_UNSOL = 2'd1;
   localparam logic [1:0] POL_BA    = 2'd2;
   localparam logic [1:0] POL_SPARE = 2'd3;

   // status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_IGNORED    = 3'd1;
   localparam logic [2:0] ST_GCR_OFF    = 3'd2;
   localparam logic [2:0] ST_NO_MEMBERS = 3'd3;
   localparam logic [2:0] ST_TABLE_FULL = 3'd4;
   localparam logic [2:0] ST_DUPLICATE  = 3'd5;

   // register indexes (paddr[2])
   localparam logic REG_RETRY_POLICY = 1'b0;
   localparam logic REG_RETRY_LIMIT  = 1'b1;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_FINISH
   } state_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic              active;
      logic [ADDR_W-1:0] addr;
      logic              hit;
      logic [IDX_W-1:0]  hit_idx;
      logic              hit_cap;
      logic              free_ok;
      logic [IDX_W-1:0]  free_idx;
   } probe_type;

   // table update broadcast
   typedef struct packed {
      logic              en;
      logic              clear;
      logic [IDX_W-1:0]  idx;
      logic              cap;
      logic [ADDR_W-1:0] addr;
   } write_type;

endpackage

@@ design/grpm_cell.sv @@
// One station table entry plus one stage of the search chain.
module grpm_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [grpm_pkg::IDX_W-1:0] cell_index,
   input  grpm_pkg::probe_type       prev_probe,
   output grpm_pkg::probe_type       next_probe,
   input  grpm_pkg::write_type       wr
);

   logic                         valid_ff;
   logic                         cap_ff;
   logic [grpm_pkg::ADDR_W-1:0]  addr_ff;
   grpm_pkg::probe_type          probe_ff;
   grpm_pkg::probe_type          probe_in;
   logic                         sel;
   logic                         match;

   assign sel   = wr.en && (wr.idx == cell_index);
   assign match = valid_ff && (addr_ff == prev_probe.addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (sel) begin
         valid_ff <= !wr.clear;
      end
   end

   always_ff @(posedge clock) begin
      if (sel && !wr.clear) begin
         cap_ff  <= wr.cap;
         addr_ff <= wr.addr;
      end
   end

   always_comb begin
      probe_in = prev_probe;
      if (!prev_probe.hit && match) begin
         probe_in.hit     = 1'b1;
         probe_in.hit_idx = cell_index;
         probe_in.hit_cap = cap_ff;
      end
      if (!prev_probe.free_ok && !valid_ff) begin
         probe_in.free_ok  = 1'b1;
         probe_in.free_idx = cell_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in;
      end
   end

   assign next_probe = probe_ff;

endmodule

@@ design/groupcast_retry_policy_manager_unit.sv @@
// Groupcast retransmission policy manager.
// Request channel (req_*): one command per transfer - associate, deassociate,
// classify frame or keep-queued decision. Response channel (rsp_*): exactly one
// result transfer per request, in order. Both use valid/stall; a transfer
// completes on a clock edge with valid high and stall low.
// Classify and keep-queued requests go from idle straight to the finish state,
// which loads the result register once the output is free; associate and
// deassociate (unless the policy is no-ack) walk a chain of MAX_STATIONS cells
// one cell a cycle and capture the outcome at its end before finishing. One
// request is in flight at a time; the next request can be taken once the
// result register has loaded and the controller is back in idle.
// A finished result that the receiver stalls sits in the output register while
// the next request is taken and processed; that one then waits for the slot.
// Reset (synchronous) empties the table, zeroes the counts and the retry
// tracker, and sets retry_policy to no-ack and the retry limit to 7.
// Configuration: APB-style, always ready; write only while idle.
// 0x0 retry_policy (code 3 is stored as block ack), 0x4 retry limit.
`include "groupcast_retry_policy_manager_unit_defines.svh"

module groupcast_retry_policy_manager_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [47:0] req_sta_addr,
   input  logic        req_gcr_capable,
   input  logic        req_frame_retry,
   input  logic        req_frame_amsdu,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_chosen_policy,
   output logic        rsp_use_concealment,
   output logic        rsp_keep_queued,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_member_count,
   output logic [5:0]  rsp_legacy_count,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int N = grpm_pkg::MAX_STATIONS;
   localparam int CW = grpm_pkg::CNT_W;
   localparam int IW = grpm_pkg::IDX_W;

   // ---------------- configuration registers ----------------
   logic [1:0] policy_ff;
   logic [7:0] limit_ff;
   logic       cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= grpm_pkg::POL_NONE;
         limit_ff  <= grpm_pkg::RESET_RETRY_LIMIT;
      end else if (cfg_wr) begin
         unique case (paddr[2])
            grpm_pkg::REG_RETRY_POLICY: begin
               policy_ff <= (pwdata[1:0] == grpm_pkg::POL_SPARE) ? grpm_pkg::POL_BA
                                                                  : pwdata[1:0];
            end
            grpm_pkg::REG_RETRY_LIMIT: limit_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         grpm_pkg::REG_RETRY_POLICY: prdata = {30'd0, policy_ff};
         grpm_pkg::REG_RETRY_LIMIT:  prdata = {24'd0, limit_ff};
         default:                    prdata = 32'd0;
      endcase
   end

   // ---------------- control and request state ----------------
   grpm_pkg::state_type state_ff, state_in;

   logic [1:0]  cmd_ff, cmd_in;
   logic [47:0] addr_ff, addr_in;
   logic        cap_ff, cap_in;
   logic        retry_ff, retry_in;
   logic        amsdu_ff, amsdu_in;

   // search outcome captured from the end of the chain
   logic          hit_ff, hit_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in;
   logic          hit_cap_ff, hit_cap_in;
   logic          free_ok_ff, free_ok_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;

   logic          launch_ff, launch_in;
   grpm_pkg::write_type wr_ff, wr_in;

   logic [CW-1:0] cap_cnt_ff, cap_cnt_in;
   logic [CW-1:0] incap_cnt_ff, incap_cnt_in;
   logic [7:0]    attempt_ff, attempt_in;
   logic          tracked_ff, tracked_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_policy_ff, rsp_policy_in;
   logic        rsp_conceal_ff, rsp_conceal_in;
   logic        rsp_keep_ff, rsp_keep_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [5:0]  rsp_member_ff, rsp_member_in;
   logic [5:0]  rsp_legacy_ff, rsp_legacy_in;

   logic accept;
   logic out_free;
   logic [7:0] attempt_nx;

   // ---------------- cell chain ----------------
   grpm_pkg::probe_type chain [N+1];
   grpm_pkg::probe_type probe_head;

   always_comb begin
      probe_head        = '0;
      probe_head.active = launch_ff;
      probe_head.addr   = addr_ff;
   end

   assign chain[0] = probe_head;

   for (genvar i = 0; i < N; i++) begin : g_cell
      grpm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IW'(i)),
         .prev_probe (chain[i]),
         .next_probe (chain[i+1]),
         .wr         (wr_ff)
      );
   end

   assign req_stall = (state_ff != grpm_pkg::FSM_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // ---------------- next state and results ----------------
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      addr_in        = addr_ff;
      cap_in         = cap_ff;
      retry_in       = retry_ff;
      amsdu_in       = amsdu_ff;
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      hit_cap_in     = hit_cap_ff;
      free_ok_in     = free_ok_ff;
      free_idx_in    = free_idx_ff;
      launch_in      = 1'b0;
      wr_in          = wr_ff;
      wr_in.en       = 1'b0;
      cap_cnt_in     = cap_cnt_ff;
      incap_cnt_in   = incap_cnt_ff;
      attempt_in     = attempt_ff;
      tracked_in     = tracked_ff;
      attempt_nx     = 8'd0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_policy_in  = rsp_policy_ff;
      rsp_conceal_in = rsp_conceal_ff;
      rsp_keep_in    = rsp_keep_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_member_in  = rsp_member_ff;
      rsp_legacy_in  = rsp_legacy_ff;

      unique case (state_ff)
         grpm_pkg::FSM_IDLE: begin
            if (accept) begin
               cmd_in   = req_cmd;
               addr_in  = req_sta_addr;
               cap_in   = req_gcr_capable;
               retry_in = req_frame_retry;
               amsdu_in = req_frame_amsdu;
               // table commands need a walk unless the policy ignores them
               if ((req_cmd == grpm_pkg::CMD_ASSOC || req_cmd == grpm_pkg::CMD_DEASSOC)
                   && policy_ff != grpm_pkg::POL_NONE) begin
                  launch_in = 1'b1;
                  state_in  = grpm_pkg::FSM_SCAN;
               end else begin
                  state_in  = grpm_pkg::FSM_FINISH;
               end
            end
         end

         grpm_pkg::FSM_SCAN: begin
            if (chain[N].active) begin
               hit_in      = chain[N].hit;
               hit_idx_in  = chain[N].hit_idx;
               hit_cap_in  = chain[N].hit_cap;
               free_ok_in  = chain[N].free_ok;
               free_idx_in = chain[N].free_idx;
               state_in    = grpm_pkg::FSM_FINISH;
            end
         end

         grpm_pkg::FSM_FINISH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_policy_in  = grpm_pkg::POL_NONE;
               rsp_conceal_in = 1'b0;
               rsp_keep_in    = 1'b0;
               rsp_status_in  = grpm_pkg::ST_OK;
               state_in       = grpm_pkg::FSM_IDLE;

               unique case (cmd_ff)
                  grpm_pkg::CMD_ASSOC: begin
                     if (policy_ff == grpm_pkg::POL_NONE) begin
                        rsp_status_in = grpm_pkg::ST_IGNORED;
                     end else if (hit_ff) begin
                        rsp_status_in = grpm_pkg::ST_DUPLICATE;
                     end else if (!free_ok_ff) begin
                        rsp_status_in = grpm_pkg::ST_TABLE_FULL;
                     end else begin
                        wr_in.en    = 1'b1;
                        wr_in.clear = 1'b0;
                        wr_in.idx   = free_idx_ff;
                        wr_in.cap   = cap_ff;
                        wr_in.addr  = addr_ff;
                        if (cap_ff) begin
                           cap_cnt_in = cap_cnt_ff + CW'(1);
                        end else begin
                           incap_cnt_in = incap_cnt_ff + CW'(1);
                        end
                     end
                  end

                  grpm_pkg::CMD_DEASSOC: begin
                     if (policy_ff == grpm_pkg::POL_NONE) begin
                        rsp_status_in = grpm_pkg::ST_IGNORED;
                     end else if (hit_ff) begin
                        wr_in.en    = 1'b1;
                        wr_in.clear = 1'b1;
                        wr_in.idx   = hit_idx_ff;
                        wr_in.cap   = 1'b0;
                        wr_in.addr  = addr_ff;
                        if (hit_cap_ff) begin
                           cap_cnt_in = cap_cnt_ff - CW'(1);
                        end else begin
                           incap_cnt_in = incap_cnt_ff - CW'(1);
                        end
                     end
                  end

                  grpm_pkg::CMD_CLASSIFY: begin
                     if (retry_ff || incap_cnt_ff == '0) begin
                        rsp_policy_in = policy_ff;
                     end
                     if (policy_ff == grpm_pkg::POL_NONE) begin
                        rsp_status_in = grpm_pkg::ST_GCR_OFF;
                     end else if (cap_cnt_ff == '0) begin
                        rsp_status_in = grpm_pkg::ST_NO_MEMBERS;
                     end else if (incap_cnt_ff == '0 || amsdu_ff || retry_ff) begin
                        rsp_conceal_in = 1'b1;
                     end
                  end

                  grpm_pkg::CMD_KEEP: begin
                     if (policy_ff == grpm_pkg::POL_NONE) begin
                        rsp_status_in = grpm_pkg::ST_GCR_OFF;
                     end else if (cap_cnt_ff == '0) begin
                        rsp_status_in = grpm_pkg::ST_NO_MEMBERS;
                     end else if (policy_ff == grpm_pkg::POL_BA) begin
                        rsp_keep_in = !retry_ff && (incap_cnt_ff != '0);
                     end else begin
                        // unsolicited retry: count attempts of the same frame
                        attempt_nx = (!tracked_ff || !retry_ff) ? 8'd0 : attempt_ff + 8'd1;
                        if (attempt_nx == limit_ff) begin
                           tracked_in  = 1'b0;
                           attempt_in  = 8'd0;
                           rsp_keep_in = 1'b0;
                        end else begin
                           tracked_in  = 1'b1;
                           attempt_in  = attempt_nx;
                           rsp_keep_in = 1'b1;
                        end
                     end
                  end

                  default: ;
               endcase

               rsp_member_in = cap_cnt_in[5:0];
               rsp_legacy_in = incap_cnt_in[5:0];
            end
         end

         default: state_in = grpm_pkg::FSM_IDLE;
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= grpm_pkg::FSM_IDLE;
         launch_ff    <= 1'b0;
         wr_ff        <= '0;
         cap_cnt_ff   <= '0;
         incap_cnt_ff <= '0;
         attempt_ff   <= 8'd0;
         tracked_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         wr_ff        <= wr_in;
         cap_cnt_ff   <= cap_cnt_in;
         incap_cnt_ff <= incap_cnt_in;
         attempt_ff   <= attempt_in;
         tracked_ff   <= tracked_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      addr_ff        <= addr_in;
      cap_ff         <= cap_in;
      retry_ff       <= retry_in;
      amsdu_ff       <= amsdu_in;
      hit_ff         <= hit_in;
      hit_idx_ff     <= hit_idx_in;
      hit_cap_ff     <= hit_cap_in;
      free_ok_ff     <= free_ok_in;
      free_idx_ff    <= free_idx_in;
      rsp_policy_ff  <= rsp_policy_in;
      rsp_conceal_ff <= rsp_conceal_in;
      rsp_keep_ff    <= rsp_keep_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_member_ff  <= rsp_member_in;
      rsp_legacy_ff  <= rsp_legacy_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_chosen_policy   = rsp_policy_ff;
   assign rsp_use_concealment = rsp_conceal_ff;
   assign rsp_keep_queued     = rsp_keep_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_member_count    = rsp_member_ff;
   assign rsp_legacy_count    = rsp_legacy_ff;

   // ---------------- assertions ----------------
   // station counts never exceed the table depth
   `GRPM_ASSERT(a_count_bound, clock, reset, ((CW+1)'(cap_cnt_ff) + (CW+1)'(incap_cnt_ff)) <= (CW+1)'(N), "station count exceeds table depth")
   // a search token only leaves the chain while the controller waits for it
   `GRPM_ASSERT(a_chain_in_scan, clock, reset, chain[N].active |-> (state_ff == grpm_pkg::FSM_SCAN), "search token outside scan")
   // table updates are issued only when a result is committed
   `GRPM_ASSERT(a_write_after_finish, clock, reset, wr_ff.en |-> $past(state_ff == grpm_pkg::FSM_FINISH), "table write without commit")
   // a launch always starts a scan
   `GRPM_ASSERT_ALWAYS(a_launch_scan, clock, (!reset && launch_ff) |-> (state_ff == grpm_pkg::FSM_SCAN), "launch outside scan")

endmodule
